// ----- rtl/core/pntilt_pkg.sv -----
// ----------------------------------------------------------------------------
// pntilt_pkg
// shared types, constants and the arctangent table for the tilt angle block
// ----------------------------------------------------------------------------
package pntilt_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_W         = 18;
    localparam int NORM_BITS       = 30;
    localparam int CORDIC_STEPS    = 30;
    localparam int ISQ_STEPS       = 31;
    localparam int DIFF_W          = 33;
    localparam int PROD_W          = 66;
    localparam int MAG_W           = 66;
    localparam int SUM_W           = 61;
    localparam int ROOT_W          = 31;
    localparam int CW              = 35;
    localparam int ZW              = 34;

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    // pi rounded half up to the output grid
    localparam logic [ANGLE_W-1:0]   PI_OUT      =
        ANGLE_W'((PI_Q30 + (ZW'(1) << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));

    // atan(2^-i) in q2.30
    localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2
    };

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] first_outer_x;
        logic signed [31:0] first_outer_y;
        logic signed [31:0] first_outer_z;
        logic signed [31:0] second_outer_x;
        logic signed [31:0] second_outer_y;
        logic signed [31:0] second_outer_z;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] tilt_angle;
        logic               degenerate;
    } t_out_item;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        logic             neg_y;
    } t_norm;

    typedef struct packed {
        logic [NORM_BITS-1:0] my;
        logic                 neg_y;
        logic                 degen;
    } t_side;

    typedef struct packed {
        logic swap;
        logic degen;
    } t_csid;

endpackage

// ----- rtl/core/pntilt_normal.sv -----
// ----------------------------------------------------------------------------
// pntilt_normal
// bond vectors, cross product terms and normal magnitudes over three stages
// ----------------------------------------------------------------------------
module pntilt_normal (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  pntilt_pkg::t_in_item i_item,
    output logic                o_valid,
    output pntilt_pkg::t_norm   o_norm
);

    logic r_v1, r_v2, r_v3;
    logic signed [pntilt_pkg::DIFF_W-1:0] r_a [0:2];
    logic signed [pntilt_pkg::DIFF_W-1:0] r_b [0:2];
    logic signed [pntilt_pkg::PROD_W-1:0] r_p [0:5];
    pntilt_pkg::t_norm r_norm;

    logic [66:0] n_x, n_y, n_z, m_x, m_y, m_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: bond vectors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0] <= {i_item.center_x[31], i_item.center_x}
                    - {i_item.first_outer_x[31], i_item.first_outer_x};
            r_a[1] <= {i_item.center_y[31], i_item.center_y}
                    - {i_item.first_outer_y[31], i_item.first_outer_y};
            r_a[2] <= {i_item.center_z[31], i_item.center_z}
                    - {i_item.first_outer_z[31], i_item.first_outer_z};
            r_b[0] <= {i_item.center_x[31], i_item.center_x}
                    - {i_item.second_outer_x[31], i_item.second_outer_x};
            r_b[1] <= {i_item.center_y[31], i_item.center_y}
                    - {i_item.second_outer_y[31], i_item.second_outer_y};
            r_b[2] <= {i_item.center_z[31], i_item.center_z}
                    - {i_item.second_outer_z[31], i_item.second_outer_z};
        end
    end

    // stage 2: six cross product terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];
        end
    end

    // stage 3: normal and magnitudes
    always_comb begin
        n_x = {r_p[0][65], r_p[0]} - {r_p[1][65], r_p[1]};
        n_y = {r_p[2][65], r_p[2]} - {r_p[3][65], r_p[3]};
        n_z = {r_p[4][65], r_p[4]} - {r_p[5][65], r_p[5]};
        m_x = n_x[66] ? (~n_x + 67'd1) : n_x;
        m_y = n_y[66] ? (~n_y + 67'd1) : n_y;
        m_z = n_z[66] ? (~n_z + 67'd1) : n_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm.mx    <= m_x[65:0];
            r_norm.my    <= m_y[65:0];
            r_norm.mz    <= m_z[65:0];
            r_norm.neg_y <= n_y[66];
        end
    end

    assign o_valid = r_v3;
    assign o_norm  = r_norm;

endmodule

// ----- rtl/core/pntilt_scale.sv -----
// ----------------------------------------------------------------------------
// pntilt_scale
// common normalising shift, squares and sum of squares over five stages
// ----------------------------------------------------------------------------
module pntilt_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  pntilt_pkg::t_norm           i_norm,
    output logic                        o_valid,
    output logic [pntilt_pkg::SUM_W-1:0] o_sum,
    output pntilt_pkg::t_side           o_side
);

    localparam int CHUNK  = 11;
    localparam int CHUNKS = 6;

    logic [4:0] r_v;
    pntilt_pkg::t_norm r_a_norm, r_b_norm;
    logic [3:0] r_a_loc [0:CHUNKS-1];
    logic [CHUNKS-1:0] r_a_nz;
    logic [5:0] r_b_s;
    logic       r_b_degen;
    logic [pntilt_pkg::NORM_BITS-1:0] r_c_mx, r_c_my, r_c_mz;
    logic r_c_neg, r_c_degen;
    logic [59:0] r_d_sx, r_d_sz;
    pntilt_pkg::t_side r_d_side, r_e_side;
    logic [pntilt_pkg::SUM_W-1:0] r_e_sum;

    logic [pntilt_pkg::MAG_W-1:0] w_or;
    logic [3:0] w_loc [0:CHUNKS-1];
    logic [6:0] w_len;
    logic [pntilt_pkg::MAG_W-1:0] w_sx, w_sy, w_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // stage a: leading one inside each chunk
    always_comb begin
        w_or = i_norm.mx | i_norm.my | i_norm.mz;
        for (int c = 0; c < CHUNKS; c++) begin
            w_loc[c] = 4'd0;
            for (int b = 0; b < CHUNK; b++) begin
                if (w_or[c*CHUNK+b]) w_loc[c] = 4'(b + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_norm <= i_norm;
            for (int c = 0; c < CHUNKS; c++) begin
                r_a_loc[c] <= w_loc[c];
                r_a_nz[c]  <= (w_loc[c] != 4'd0);
            end
        end
    end

    // stage b: bit length and shift amount
    always_comb begin
        w_len = 7'd0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (r_a_nz[c]) w_len = 7'(c * CHUNK) + {3'd0, r_a_loc[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_norm  <= r_a_norm;
            r_b_s     <= (w_len > 7'(pntilt_pkg::NORM_BITS))
                       ? 6'(w_len - 7'(pntilt_pkg::NORM_BITS)) : 6'd0;
            r_b_degen <= (w_len == 7'd0);
        end
    end

    // stage c: shift
    always_comb begin
        w_sx = r_b_norm.mx >> r_b_s;
        w_sy = r_b_norm.my >> r_b_s;
        w_sz = r_b_norm.mz >> r_b_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_mx    <= w_sx[pntilt_pkg::NORM_BITS-1:0];
            r_c_my    <= w_sy[pntilt_pkg::NORM_BITS-1:0];
            r_c_mz    <= w_sz[pntilt_pkg::NORM_BITS-1:0];
            r_c_neg   <= r_b_norm.neg_y;
            r_c_degen <= r_b_degen;
        end
    end

    // stage d: squares, stage e: sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sx         <= r_c_mx * r_c_mx;
            r_d_sz         <= r_c_mz * r_c_mz;
            r_d_side.my    <= r_c_my;
            r_d_side.neg_y <= r_c_neg;
            r_d_side.degen <= r_c_degen;
            r_e_sum        <= {1'b0, r_d_sx} + {1'b0, r_d_sz};
            r_e_side       <= r_d_side;
        end
    end

    assign o_valid = r_v[4];
    assign o_sum   = r_e_sum;
    assign o_side  = r_e_side;

endmodule

// ----- rtl/core/pntilt_isqrt.sv -----
// ----------------------------------------------------------------------------
// pntilt_isqrt
// integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module pntilt_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [pntilt_pkg::SUM_W-1:0]  i_sum,
    input  pntilt_pkg::t_side             i_side,
    output logic                          o_valid,
    output logic [pntilt_pkg::ROOT_W-1:0] o_root,
    output pntilt_pkg::t_side             o_side
);

    localparam int N = pntilt_pkg::ISQ_STEPS;

    logic [N-1:0] r_vld;
    logic [pntilt_pkg::SUM_W-1:0] r_rem [0:N-1];
    logic [61:0]                  r_res [0:N-1];
    pntilt_pkg::t_side            r_sd  [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * g);
        logic [pntilt_pkg::SUM_W-1:0] w_rem;
        logic [61:0] w_res, w_try;
        pntilt_pkg::t_side w_sd;
        logic w_take;

        if (g == 0) begin : g_first
            assign w_rem = i_sum;
            assign w_res = '0;
            assign w_sd  = i_side;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_res = r_res[g-1];
            assign w_sd  = r_sd[g-1];
        end

        assign w_try  = w_res + BIT;
        assign w_take = ({1'b0, w_rem} >= w_try);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_take ? (w_rem - w_try[pntilt_pkg::SUM_W-1:0]) : w_rem;
                r_res[g] <= w_take ? ((w_res >> 1) + BIT) : (w_res >> 1);
                r_sd[g]  <= w_sd;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_res[N-1][pntilt_pkg::ROOT_W-1:0];
    assign o_side  = r_sd[N-1];

endmodule

// ----- rtl/core/pntilt_cordic.sv -----
// ----------------------------------------------------------------------------
// pntilt_cordic
// vectoring cordic arctangent, one micro-rotation per pipeline stage
// ----------------------------------------------------------------------------
module pntilt_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [pntilt_pkg::ROOT_W-1:0] i_root,
    input  pntilt_pkg::t_side             i_side,
    output logic                          o_valid,
    output logic signed [pntilt_pkg::ZW-1:0] o_z,
    output pntilt_pkg::t_csid             o_csid
);

    localparam int N  = pntilt_pkg::CORDIC_STEPS;
    localparam int CW = pntilt_pkg::CW;
    localparam int ZW = pntilt_pkg::ZW;

    logic [N-1:0] r_vld;
    logic signed [CW-1:0] r_x [0:N-1];
    logic signed [CW-1:0] r_y [0:N-1];
    logic signed [ZW-1:0] r_z [0:N-1];
    pntilt_pkg::t_csid    r_cs [0:N-1];

    logic w_swap;
    logic signed [CW-1:0] w_x0, w_y0;

    // negative y: rotate the problem by a quarter turn
    always_comb begin
        w_swap = i_side.neg_y && (i_side.my != '0);
        w_x0 = w_swap ? CW'(i_root) : CW'(i_side.my);
        w_y0 = w_swap ? CW'(i_side.my) : CW'(i_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [CW-1:0] w_x, w_y, w_xs, w_ys;
        logic signed [ZW-1:0] w_z;
        pntilt_pkg::t_csid w_cs;

        if (g == 0) begin : g_first
            assign w_x  = w_x0;
            assign w_y  = w_y0;
            assign w_z  = '0;
            assign w_cs = '{swap: w_swap, degen: i_side.degen};
        end else begin : g_next
            assign w_x  = r_x[g-1];
            assign w_y  = r_y[g-1];
            assign w_z  = r_z[g-1];
            assign w_cs = r_cs[g-1];
        end

        assign w_xs = w_x >>> g;
        assign w_ys = w_y >>> g;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[CW-1]) begin
                    r_x[g] <= w_x + w_ys;
                    r_y[g] <= w_y - w_xs;
                    r_z[g] <= w_z + ZW'(pntilt_pkg::ATAN_Q30[g]);
                end else begin
                    r_x[g] <= w_x - w_ys;
                    r_y[g] <= w_y + w_xs;
                    r_z[g] <= w_z - ZW'(pntilt_pkg::ATAN_Q30[g]);
                end
                r_cs[g] <= w_cs;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_z     = r_z[N-1];
    assign o_csid  = r_cs[N-1];

endmodule

// ----- rtl/core/plane_normal_tilt_angle.sv -----
// ----------------------------------------------------------------------------
// plane_normal_tilt_angle
// angle between the plane normal of a three-atom molecule and the y axis
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//
//  one item enters per cycle while the pipeline enable is high; each result
//  passes 3 normal stages, 5 scaling stages, 31 square root stages and 30
//  cordic stages (bit-per-stage root and cordic), then 1 output register
//  a single pipeline enable moves every stage; it is low only while a result
//  sits in the output register and the sink holds i_out_ready low
//  synchronous active-low reset clears every valid bit; data needs no reset
//
module plane_normal_tilt_angle (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pntilt_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pntilt_pkg::t_out_item o_out_item
);

    localparam int RSH = 30 - pntilt_pkg::ANGLE_FRAC_BITS;

    logic w_en;

    // stage to stage links
    logic                          w_nrm_v, w_scl_v, w_sq_v, w_cor_v;
    pntilt_pkg::t_norm             w_nrm;
    logic [pntilt_pkg::SUM_W-1:0]  w_sum;
    pntilt_pkg::t_side             w_side_s, w_side_q;
    logic [pntilt_pkg::ROOT_W-1:0] w_root;
    logic signed [pntilt_pkg::ZW-1:0] w_z;
    pntilt_pkg::t_csid             w_cs;

    // final angle arithmetic
    logic signed [pntilt_pkg::ZW-1:0] w_zf, w_zc;
    logic [pntilt_pkg::ZW-1:0]        w_zr;
    pntilt_pkg::t_out_item            n_out;

    logic                  r_out_valid;
    pntilt_pkg::t_out_item r_out_item;

    // whole pipeline stalls only when the output register is full and held
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    pntilt_normal u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (w_nrm_v),
        .o_norm  (w_nrm)
    );

    pntilt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_nrm_v),
        .i_norm  (w_nrm),
        .o_valid (w_scl_v),
        .o_sum   (w_sum),
        .o_side  (w_side_s)
    );

    pntilt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_scl_v),
        .i_sum   (w_sum),
        .i_side  (w_side_s),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_side_q)
    );

    pntilt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_root  (w_root),
        .i_side  (w_side_q),
        .o_valid (w_cor_v),
        .o_z     (w_z),
        .o_csid  (w_cs)
    );

    // quarter turn back, clamp to 0..pi, round half up to the output grid
    always_comb begin
        w_zf = w_cs.swap ? (w_z + pntilt_pkg::HALF_PI_Q30) : w_z;
        if (w_zf[pntilt_pkg::ZW-1]) begin
            w_zc = '0;
        end else if (w_zf > pntilt_pkg::PI_Q30) begin
            w_zc = pntilt_pkg::PI_Q30;
        end else begin
            w_zc = w_zf;
        end
        w_zr = (w_zc + (pntilt_pkg::ZW'(1) << (RSH - 1))) >> RSH;
        if (w_cs.degen) begin
            n_out.tilt_angle = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.tilt_angle = w_zr[pntilt_pkg::ANGLE_W-1:0];
            n_out.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cor_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a degenerate molecule always reports angle zero
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.degenerate |-> o_out_item.tilt_angle == '0)
        else $error("degenerate item with nonzero angle");

    // angle never exceeds pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.tilt_angle <= pntilt_pkg::PI_OUT)
        else $error("angle above pi");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled output blocks intake
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken during output stall");

endmodule
